// ===== hw/rtl/tps_pkg.sv =====
// Shared types, widths and codes for the trajectory point search unit.
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

    // Default table depth.
    localparam int MAX_POINTS_DEFAULT = 256;

    // Field widths.
    localparam int REQ_W     = 3;
    localparam int COORD_W   = 24;
    localparam int TIME_W    = 32;
    localparam int INDEX_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int BUFFER_W  = 40;
    localparam int EPSILON_W = 20;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    // Arithmetic widths of the distance pipeline.
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * COORD_W + 1;
    localparam int DIST_W = SQ_W + 1;
    localparam int LIM_W  = DIST_W + 1;
    localparam int TSUM_W = TIME_W + 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_NEAREST     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_NEAREST_BUF = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LOWER_BOUND = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY        = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TIME_ORDER   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd3;

    // Register indexes, taken from bit 3 of the byte address.
    localparam logic REG_NEAREST_BUFFER = 1'b0;
    localparam logic REG_TIME_EPSILON   = 1'b1;

    // One stored trajectory point.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [TIME_W-1:0]  t;
    } point_t;

    // Per-cell control.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // Control handed from the sequencer to the scan pipeline.
    typedef struct packed {
        logic start;
        logic issue;
        logic in_range;
        logic below_last;
        logic use_buffer;
    } scan_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trajectory_point_search_unit.sv =====
// Top level of the trajectory point search unit: sequencer, point chain and register port.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                         Direction
// input     in_valid/in_ready, req_type, pos_x, pos_y,      in (ready out)
//           time_value
// output    out_valid/out_ready, point_index, status        out (ready in)
// config    psel, penable, pwrite, paddr, pwdata, prdata,   APB-style, pready tied high
//           pready
//
// Clear, append and unknown requests, and queries on an empty table, pass from the
// sequencer's result registers to the output register. A query rotates the whole point
// chain once, one point past the head cell per cycle, and the sequencer then waits for
// the scan pipeline to drain. The next item is accepted as soon as the sequencer
// is idle, even while the previous result still waits in the output register; a result
// stays in the sequencer until the output register is free. Reset clears the point count,
// both registers and all handshake state; the stored points are not cleared.

module trajectory_point_search_unit
    import tps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [REQ_W-1:0]           req_type,
    input  wire logic signed [COORD_W-1:0]  pos_x,
    input  wire logic signed [COORD_W-1:0]  pos_y,
    input  wire logic signed [TIME_W-1:0]   time_value,

    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [INDEX_W-1:0]              point_index,
    output logic [STATUS_W-1:0]             status,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [PADDR_W-1:0]         paddr,
    input  wire logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]              prdata,
    output logic                            pready
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SCN_W = $clog2(MAX_POINTS + 3);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Sequencer state.
    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [SCN_W-1:0]    scan_cnt_reg;
    logic [SCN_W-1:0]    scan_cnt_next;
    logic                is_query_reg;
    logic                is_query_next;

    // Item held for the scan and the result of the immediate requests.
    logic [REQ_W-1:0]    req_reg;
    point_t              query_reg;
    logic signed [TIME_W-1:0] last_time_reg;
    logic [IDX_W-1:0]    res_idx_reg;
    logic [IDX_W-1:0]    res_idx_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;

    // Output register.
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  point_index_reg;
    logic [STATUS_W-1:0] status_reg;

    // Configuration registers.
    logic [BUFFER_W-1:0]  nearest_buffer_reg;
    logic [EPSILON_W-1:0] time_epsilon_reg;

    logic                accept;
    logic                append_load;
    logic                scan_start;
    logic                issue;
    logic                out_load;
    logic                cfg_write;
    point_t              append_point;
    point_t              cell_q [MAX_POINTS];
    scan_ctrl_t          scan_ctrl;
    logic [IDX_W-1:0]    near_idx;
    logic [IDX_W-1:0]    lb_idx;
    logic                lb_found;
    logic [IDX_W-1:0]    last_idx;
    logic [IDX_W-1:0]    final_idx;
    logic [STATUS_W-1:0] final_status;
    logic [IDX_W+INDEX_W-1:0] idx_wide;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;
    assign issue    = (state_reg == ST_SCAN) && (scan_cnt_reg < SCN_W'(MAX_POINTS));
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    assign append_point.x = pos_x;
    assign append_point.y = pos_y;
    assign append_point.t = time_value;

    // Request decode and sequencing.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_cnt_next   = scan_cnt_reg;
        is_query_next   = is_query_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;
        append_load     = 1'b0;
        scan_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_idx_next    = '0;
                    res_status_next = STATUS_OK;
                    is_query_next   = 1'b0;
                    state_next      = ST_FINISH;
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        REQ_APPEND:
                        begin
                            // Fullness is checked before the time order.
                            if (count_reg >= CNT_W'(MAX_POINTS))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else if (count_reg != '0 && time_value <= last_time_reg)
                            begin
                                res_status_next = STATUS_TIME_ORDER;
                            end
                            else
                            begin
                                append_load  = 1'b1;
                                res_idx_next = count_reg[IDX_W-1:0];
                                count_next   = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_NEAREST, REQ_NEAREST_BUF, REQ_LOWER_BOUND:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                is_query_next = 1'b1;
                                scan_start    = 1'b1;
                                scan_cnt_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // The scan runs on after the chain stops until the last point has left the pipeline.
                scan_cnt_next = scan_cnt_reg + SCN_W'(1);
                if (scan_cnt_reg == SCN_W'(MAX_POINTS + 2))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            is_query_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            is_query_reg <= is_query_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
        if (accept)
        begin
            req_reg   <= req_type;
            query_reg <= append_point;
        end
        if (append_load)
        begin
            last_time_reg <= time_value;
        end
        if (out_load)
        begin
            point_index_reg <= idx_wide[INDEX_W-1:0];
            status_reg      <= final_status;
        end
    end

    // The point chain. Cell i takes its neighbour's point while a query rotates the
    // chain, so the head cell presents the points in index order; a full revolution
    // leaves every point where it started. An append writes the cell at the fill count.
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        cell_ctrl_t cell_ctrl;

        assign cell_ctrl.shift = issue;
        assign cell_ctrl.load  = append_load && (count_reg == CNT_W'(i));

        tps_cell u_cell
        (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .load_data (append_point),
            .neighbour (cell_q[(i + 1) % MAX_POINTS]),
            .q         (cell_q[i])
        );
    end

    // Only points below the fill count take part; the lower-bound search also
    // leaves out the last point, which is handled by the end test below.
    assign scan_ctrl.start      = scan_start;
    assign scan_ctrl.issue      = issue;
    assign scan_ctrl.in_range   = scan_cnt_reg < SCN_W'(count_reg);
    assign scan_ctrl.below_last = ((SCN_W + 1)'(scan_cnt_reg) + (SCN_W + 1)'(1))
                                < (SCN_W + 1)'(count_reg);
    assign scan_ctrl.use_buffer = (req_reg == REQ_NEAREST_BUF);

    tps_scan #(
        .IDX_W (IDX_W)
    ) u_scan
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (scan_ctrl),
        .head_idx       (scan_cnt_reg[IDX_W-1:0]),
        .head           (cell_q[0]),
        .query          (query_reg),
        .nearest_buffer (nearest_buffer_reg),
        .time_epsilon   (time_epsilon_reg),
        .near_idx       (near_idx),
        .lb_idx         (lb_idx),
        .lb_found       (lb_found)
    );

    // Result selection. A time at or past the last stored time, or one that no
    // earlier point reaches, gives the last index.
    assign last_idx = count_reg[IDX_W-1:0] - IDX_W'(1);

    always_comb
    begin
        final_idx    = res_idx_reg;
        final_status = res_status_reg;
        if (is_query_reg)
        begin
            final_status = STATUS_OK;
            if (req_reg == REQ_LOWER_BOUND)
            begin
                if (query_reg.t >= last_time_reg || !lb_found)
                begin
                    final_idx = last_idx;
                end
                else
                begin
                    final_idx = lb_idx;
                end
            end
            else
            begin
                final_idx = near_idx;
            end
        end
    end

    // Indexes are reported in their low eight bits.
    assign idx_wide = {{INDEX_W{1'b0}}, final_idx};

    assign out_valid   = out_valid_reg;
    assign point_index = point_index_reg;
    assign status      = status_reg;

    // Register port. Bit 3 of the byte address selects the register.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nearest_buffer_reg <= '0;
            time_epsilon_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3])
                REG_NEAREST_BUFFER:
                begin
                    nearest_buffer_reg <= pwdata[BUFFER_W-1:0];
                end
                REG_TIME_EPSILON:
                begin
                    time_epsilon_reg <= pwdata[EPSILON_W-1:0];
                end
                default:
                begin
                    nearest_buffer_reg <= nearest_buffer_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3])
            REG_NEAREST_BUFFER:
            begin
                prdata = {{(PDATA_W-BUFFER_W){1'b0}}, nearest_buffer_reg};
            end
            REG_TIME_EPSILON:
            begin
                prdata = {{(PDATA_W-EPSILON_W){1'b0}}, time_epsilon_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tps_cell.sv =====
// One storage cell of the rotating point chain.
`timescale 1ns / 1ps
`default_nettype none

module tps_cell
    import tps_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire point_t     load_data,
    input  wire point_t     neighbour,
    output point_t          q
);

    point_t pt_reg;

    // The cell either takes a freshly appended point or the point of its neighbour.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pt_reg <= load_data;
        end
        else if (ctrl.shift)
        begin
            pt_reg <= neighbour;
        end
    end

    assign q = pt_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tps_scan.sv =====
// Distance and time comparison pipeline with the running search accumulators.
`timescale 1ns / 1ps
`default_nettype none

module tps_scan
    import tps_pkg::*;
#(
    parameter int IDX_W = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire scan_ctrl_t           ctrl,
    input  wire logic [IDX_W-1:0]     head_idx,
    input  wire point_t               head,
    input  wire point_t               query,
    input  wire logic [BUFFER_W-1:0]  nearest_buffer,
    input  wire logic [EPSILON_W-1:0] time_epsilon,
    output logic [IDX_W-1:0]          near_idx,
    output logic [IDX_W-1:0]          lb_idx,
    output logic                      lb_found
);

    // Stage 1: coordinate differences and the time test.
    logic                     v1_reg;
    logic                     bl1_reg;
    logic                     tok1_reg;
    logic [IDX_W-1:0]         idx1_reg;
    logic signed [DIFF_W-1:0] dx1_reg;
    logic signed [DIFF_W-1:0] dy1_reg;

    // Stage 2: squares.
    logic                     v2_reg;
    logic                     bl2_reg;
    logic                     tok2_reg;
    logic [IDX_W-1:0]         idx2_reg;
    logic [SQ_W-1:0]          sqx2_reg;
    logic [SQ_W-1:0]          sqy2_reg;

    // Stage 3: squared distance.
    logic                     v3_reg;
    logic                     bl3_reg;
    logic                     tok3_reg;
    logic [IDX_W-1:0]         idx3_reg;
    logic [DIST_W-1:0]        d3_reg;

    // Accumulators.
    logic                     have_reg;
    logic [DIST_W-1:0]        best_reg;
    logic [IDX_W-1:0]         near_idx_reg;
    logic                     found_reg;
    logic [IDX_W-1:0]         lb_idx_reg;

    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dy;
    logic signed [TSUM_W-1:0]   t_sum;
    logic signed [TSUM_W-1:0]   t_query;
    logic signed [2*DIFF_W-1:0] sqx;
    logic signed [2*DIFF_W-1:0] sqy;
    logic [LIM_W-1:0]           lim;
    logic                       win;

    assign dx      = {head.x[COORD_W-1], head.x} - {query.x[COORD_W-1], query.x};
    assign dy      = {head.y[COORD_W-1], head.y} - {query.y[COORD_W-1], query.y};
    assign t_sum   = {{2{head.t[TIME_W-1]}}, head.t}
                   + $signed({{(TSUM_W-EPSILON_W){1'b0}}, time_epsilon});
    assign t_query = {{2{query.t[TIME_W-1]}}, query.t};

    assign sqx = dx1_reg * dx1_reg;
    assign sqy = dy1_reg * dy1_reg;

    // Buffered limit is exact at this width, so it never wraps.
    assign lim = {1'b0, best_reg} + {{(LIM_W-BUFFER_W){1'b0}}, nearest_buffer};

    always_comb
    begin
        if (!have_reg)
        begin
            win = 1'b1;
        end
        else if (ctrl.use_buffer)
        begin
            win = {1'b0, d3_reg} < lim;
        end
        else
        begin
            win = d3_reg < best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            have_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.issue & ctrl.in_range;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (ctrl.start)
            begin
                have_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (v3_reg)
            begin
                if (win)
                begin
                    have_reg <= 1'b1;
                end
                if (bl3_reg && tok3_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bl1_reg  <= ctrl.below_last;
        tok1_reg <= t_sum >= t_query;
        idx1_reg <= head_idx;
        dx1_reg  <= dx;
        dy1_reg  <= dy;

        bl2_reg  <= bl1_reg;
        tok2_reg <= tok1_reg;
        idx2_reg <= idx1_reg;
        sqx2_reg <= sqx[SQ_W-1:0];
        sqy2_reg <= sqy[SQ_W-1:0];

        bl3_reg  <= bl2_reg;
        tok3_reg <= tok2_reg;
        idx3_reg <= idx2_reg;
        d3_reg   <= {1'b0, sqx2_reg} + {1'b0, sqy2_reg};

        if (v3_reg && !ctrl.start)
        begin
            if (win)
            begin
                best_reg     <= d3_reg;
                near_idx_reg <= idx3_reg;
            end
            if (bl3_reg && tok3_reg && !found_reg)
            begin
                lb_idx_reg <= idx3_reg;
            end
        end
    end

    assign near_idx = near_idx_reg;
    assign lb_idx   = lb_idx_reg;
    assign lb_found = found_reg;

endmodule

`default_nettype wire
